[hw/rtl/tcw_pkg.sv]
// Shared constants and types for the text console writer.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Field widths fixed by the item format.
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int CURSOR_W = 11;
  localparam int ATTR_W   = 8;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int SWEEP_W = $clog2(CELLS + 1);
  localparam int COL_W   = $clog2(COLUMNS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CHAR_W-1:0]     NEWLINE_CODE  = 8'h0a;
  localparam logic [CHAR_W-1:0]     BLANK_CODE    = 8'h20;
  localparam logic [CFG_DATA_W-1:0] FLOOR_RESET   = 11'd2;
  localparam logic [ATTR_W-1:0]     ATTR_RESET    = 8'h0f;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT       = 2'd0,
    ACT_BACKSPACE = 2'd1,
    ACT_CLEAR     = 2'd2,
    ACT_READ      = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BACKSPACE_FLOOR = 2'd0,
    REG_TEXT_ATTR       = 2'd1
  } cfg_reg_t;

endpackage

[hw/rtl/tcw_in_if.sv]
// Input item channel of the text console writer.
interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::ACTION_W-1:0] action;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::CURSOR_W-1:0] cell_index;

  modport source (output valid, output action, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input action, input char_code, input cell_index,
                output ready);
endinterface

[hw/rtl/tcw_out_if.sv]
// Result item channel of the text console writer.
interface tcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CURSOR_W-1:0] cursor_cell;
  logic [tcw_pkg::CHAR_W-1:0]   cell_char;
  logic [tcw_pkg::ATTR_W-1:0]   cell_attr;

  modport source (output valid, output cursor_cell, output cell_char, output cell_attr,
                  input ready);
  modport sink (input valid, input cursor_cell, input cell_char, input cell_attr,
                output ready);
endinterface

[hw/rtl/tcw_cfg_if.sv]
// Configuration write channel of the text console writer.
interface tcw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::CFG_IDX_W-1:0]  index;
  logic [tcw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/tcw_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/text_console_writer_unit.sv]
// Text console writer: character screen memory with cursor, scroll, backspace, clear and read.
// Put without scroll and backspace give their result in the cycle after acceptance; a read
// goes via S_READ, a clear sweeps in S_CLEAR, a scrolling put sweeps in S_SCROLL, then S_PUT.
// Items are taken only in S_IDLE with the result register free; scroll and clear sweep the
// screen memory one cell per cycle through its single write port.
// Reset: synchronous, active low; a blanking pass in S_INIT follows with in_ch.ready low.
module text_console_writer_unit (
  input logic     clk,
  input logic     rst_n,
  tcw_in_if.sink  in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink cfg_ch
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CLEAR, S_SCROLL, S_PUT, S_READ
  } state_t;

  state_t                         state_r, state_nxt;
  logic [tcw_pkg::CURSOR_W-1:0]   cursor_r, cursor_nxt;
  logic [tcw_pkg::COL_W-1:0]      col_r, col_nxt;
  logic [tcw_pkg::SWEEP_W-1:0]    sweep_r, sweep_nxt;
  logic                           pend_r, pend_nxt;
  logic                           blank_r, blank_nxt;
  logic [tcw_pkg::ADDR_W-1:0]     wb_addr_r, wb_addr_nxt;
  logic [tcw_pkg::CHAR_W-1:0]     code_r, code_nxt;
  logic                           rd_ok_r, rd_ok_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [tcw_pkg::CURSOR_W-1:0]   out_cursor_r, out_cursor_nxt;
  logic [tcw_pkg::CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic [tcw_pkg::ATTR_W-1:0]     out_attr_r, out_attr_nxt;
  logic [tcw_pkg::CFG_DATA_W-1:0] floor_r;
  logic [tcw_pkg::ATTR_W-1:0]     attr_r;

  logic                           in_acc;
  logic                           cfg_acc;
  logic                           out_free;
  logic                           sweep_last;
  logic                           load;
  logic [tcw_pkg::CHAR_W-1:0]     ld_char;
  logic [tcw_pkg::ATTR_W-1:0]     ld_attr;
  logic [tcw_pkg::CHAR_W-1:0]     put_code;
  logic [tcw_pkg::SWEEP_W-1:0]    src_addr;
  logic [tcw_pkg::CURSOR_W-1:0]   bs_cell;

  logic                           ram_we;
  logic [tcw_pkg::ADDR_W-1:0]     ram_wa;
  logic [tcw_pkg::CHAR_W-1:0]     ram_wd;
  logic [tcw_pkg::ADDR_W-1:0]     ram_ra;
  logic [tcw_pkg::CHAR_W-1:0]     ram_rd;

  tcw_ram #(
    .WIDTH (tcw_pkg::CHAR_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc    = cfg_ch.valid && cfg_ch.ready;
  assign sweep_last = (sweep_r == tcw_pkg::SWEEP_W'(tcw_pkg::CELLS));
  assign src_addr   = sweep_r + tcw_pkg::SWEEP_W'(tcw_pkg::COLUMNS);
  assign bs_cell    = cursor_r - tcw_pkg::CURSOR_W'(1);
  assign put_code   = (state_r == S_PUT) ? code_r : in_ch.char_code;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cursor_cell = out_cursor_r;
  assign out_ch.cell_char   = out_char_r;
  assign out_ch.cell_attr   = out_attr_r;

  always_comb begin
    state_nxt   = state_r;
    cursor_nxt  = cursor_r;
    col_nxt     = col_r;
    sweep_nxt   = sweep_r;
    pend_nxt    = 1'b0;
    blank_nxt   = blank_r;
    wb_addr_nxt = wb_addr_r;
    code_nxt    = code_r;
    rd_ok_nxt   = rd_ok_r;
    load        = 1'b0;
    ld_char     = '0;
    ld_attr     = '0;
    ram_we      = 1'b0;
    ram_wa      = wb_addr_r;
    ram_wd      = blank_r ? tcw_pkg::BLANK_CODE : ram_rd;
    ram_ra      = in_ch.cell_index[tcw_pkg::ADDR_W-1:0];

    // The sweep writes in the cycle after its read, so a copied cell is written
    // when its source byte comes out of the memory.
    if (pend_r) begin
      ram_we = 1'b1;
    end

    case (state_r)
      S_INIT, S_CLEAR, S_SCROLL: begin
        if (!sweep_last) begin
          pend_nxt    = 1'b1;
          wb_addr_nxt = sweep_r[tcw_pkg::ADDR_W-1:0];
          blank_nxt   = !((state_r == S_SCROLL) &&
                          (sweep_r < tcw_pkg::SWEEP_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS)));
          ram_ra      = src_addr[tcw_pkg::ADDR_W-1:0];
          sweep_nxt   = sweep_r + tcw_pkg::SWEEP_W'(1);
        end else begin
          sweep_nxt = '0;
          case (state_r)
            S_INIT: begin
              state_nxt = S_IDLE;
            end
            S_CLEAR: begin
              cursor_nxt = '0;
              col_nxt    = '0;
              load       = 1'b1;
              state_nxt  = S_IDLE;
            end
            default: begin
              cursor_nxt = cursor_r - tcw_pkg::CURSOR_W'(tcw_pkg::COLUMNS);
              state_nxt  = S_PUT;
            end
          endcase
        end
      end

      S_IDLE, S_PUT: begin
        if (state_r == S_PUT || in_acc) begin
          case ((state_r == S_PUT) ? tcw_pkg::ACT_PUT : tcw_pkg::action_t'(in_ch.action))
            tcw_pkg::ACT_PUT: begin
              if (cursor_r >= tcw_pkg::CURSOR_W'(tcw_pkg::CELLS)) begin
                code_nxt  = in_ch.char_code;
                sweep_nxt = '0;
                state_nxt = S_SCROLL;
              end else begin
                load      = 1'b1;
                state_nxt = S_IDLE;
                if (put_code == tcw_pkg::NEWLINE_CODE) begin
                  cursor_nxt = cursor_r - tcw_pkg::CURSOR_W'(col_r)
                               + tcw_pkg::CURSOR_W'(tcw_pkg::COLUMNS);
                  col_nxt    = '0;
                end else begin
                  ram_we     = 1'b1;
                  ram_wa     = cursor_r[tcw_pkg::ADDR_W-1:0];
                  ram_wd     = put_code;
                  cursor_nxt = cursor_r + tcw_pkg::CURSOR_W'(1);
                  col_nxt    = (col_r == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) ?
                               '0 : col_r + tcw_pkg::COL_W'(1);
                end
              end
            end
            tcw_pkg::ACT_BACKSPACE: begin
              load = 1'b1;
              if ((cursor_r > floor_r) && (cursor_r != '0)) begin
                ram_we     = 1'b1;
                ram_wa     = bs_cell[tcw_pkg::ADDR_W-1:0];
                ram_wd     = tcw_pkg::BLANK_CODE;
                cursor_nxt = bs_cell;
                col_nxt    = (col_r == '0) ?
                             tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1) : col_r - tcw_pkg::COL_W'(1);
              end
            end
            tcw_pkg::ACT_CLEAR: begin
              sweep_nxt = '0;
              state_nxt = S_CLEAR;
            end
            default: begin
              rd_ok_nxt = (in_ch.cell_index < tcw_pkg::CURSOR_W'(tcw_pkg::CELLS));
              state_nxt = S_READ;
            end
          endcase
        end
      end

      S_READ: begin
        load      = 1'b1;
        ld_char   = rd_ok_r ? ram_rd : '0;
        ld_attr   = rd_ok_r ? attr_r : '0;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_cursor_nxt = out_cursor_r;
    out_char_nxt   = out_char_r;
    out_attr_nxt   = out_attr_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_cursor_nxt = cursor_nxt;
      out_char_nxt   = ld_char;
      out_attr_nxt   = ld_attr;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r    <= wb_addr_nxt;
    blank_r      <= blank_nxt;
    code_r       <= code_nxt;
    rd_ok_r      <= rd_ok_nxt;
    out_cursor_r <= out_cursor_nxt;
    out_char_r   <= out_char_nxt;
    out_attr_r   <= out_attr_nxt;
    if (!rst_n) begin
      state_r     <= S_INIT;
      cursor_r    <= '0;
      col_r       <= '0;
      sweep_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      floor_r     <= tcw_pkg::FLOOR_RESET;
      attr_r      <= tcw_pkg::ATTR_RESET;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      sweep_r     <= sweep_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_acc) begin
        case (tcw_pkg::cfg_reg_t'(cfg_ch.index))
          tcw_pkg::REG_BACKSPACE_FLOOR: floor_r <= cfg_ch.data;
          tcw_pkg::REG_TEXT_ATTR:       attr_r  <= cfg_ch.data[tcw_pkg::ATTR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // The cursor never goes beyond the cell just past the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= tcw_pkg::CURSOR_W'(tcw_pkg::CELLS))
    else $error("cursor beyond end of screen");

  // Past the end of the screen the tracked column must be zero.
  a_col_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_r == tcw_pkg::CURSOR_W'(tcw_pkg::CELLS)) |-> (col_r == '0))
    else $error("column out of step with cursor");

  // Delayed sweep writes only occur while a sweep is running or just finishing.
  a_pend_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_INIT || state_r == S_CLEAR || state_r == S_SCROLL))
    else $error("sweep write outside a sweep");

  // After a scroll the cursor is back on the screen.
  a_put_after_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |-> (cursor_r < tcw_pkg::CURSOR_W'(tcw_pkg::CELLS)))
    else $error("cursor still past the end after scroll");

  // A new result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("result register overwritten");

endmodule
